// ===== rtl/core/khp_pkg.sv =====
// Shared types, constants and fixed-point helpers of the horizon predictor.
`default_nettype none
package khp_pkg;

    localparam int HORIZON  = 32;
    localparam int AXES     = 3;
    localparam int K_W      = $clog2(HORIZON + 1);
    localparam int A_W      = (HORIZON > 1) ? $clog2(HORIZON) : 1;
    localparam int DIV_BITS = 48;
    localparam int DCNT_W   = $clog2(DIV_BITS + 1);
    localparam int CIDX_W   = 4;
    localparam int STEPS_MAX = 65535;

    localparam logic signed [31:0] Q_ONE  = 32'sd65536;
    localparam logic signed [31:0] S_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN  = 32'sh8000_0000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_STEP_TIME  = 4'd0,
        CFG_MEAS_NOISE = 4'd1,
        CFG_PROC_PP    = 4'd2,
        CFG_PROC_PV    = 4'd3,
        CFG_PROC_VV    = 4'd4,
        CFG_INIT_X     = 4'd5,
        CFG_INIT_Y     = 4'd6,
        CFG_INIT_Z     = 4'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_MEAS   = 2'd0,
        MODE_REPRED = 2'd1,
        MODE_EXTRAP = 2'd2
    } mode_t;

    typedef struct packed {
        logic               meas_valid;
        logic signed [31:0] meas_x;
        logic signed [31:0] meas_y;
        logic signed [31:0] meas_z;
    } tick_t;

    typedef struct packed {
        logic               last;
        logic               order;
        logic signed [31:0] val_x;
        logic signed [31:0] val_y;
        logic signed [31:0] val_z;
        logic [30:0]        var_x;
        logic [30:0]        var_y;
        logic [30:0]        var_z;
    } result_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] ppos;
        logic signed [31:0] pcov;
        logic signed [31:0] pvel;
    } lane_t;

    typedef lane_t [AXES-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? S_MIN : S_MAX;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            return s[32] ? S_MIN : S_MAX;
        return s[31:0];
    endfunction

    // Q16.16 product: floor of the full product over 2^16, then saturated.
    function automatic logic signed [31:0] q_of(input logic signed [63:0] p);
        if (p[63:47] == {17{p[63]}})
            return p[47:16];
        return p[63] ? S_MIN : S_MAX;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kalman_horizon_predictor_core.sv =====
// Top level of the multi-step constant-velocity Kalman horizon predictor.
//
// Each accepted tick beat runs one update of a three-axis constant-velocity
// Kalman predictor in saturating signed Q16.16 and then streams 2*HORIZON
// result beats, position then velocity for each step, the last one flagged.
// Ticks before the first measurement are accepted and dropped. The horizon
// (prediction, velocity and prior covariance of every step, all three axes
// side by side) lives in one RAM row per step; the posterior covariance and
// the configuration live in flip-flops. The block works on one tick at a
// time and holds tick_stall high until all results of the tick have been
// loaded into the output register. Every product goes through a registered
// multiplier per axis, and a measurement tick waits on the gain divisions.
// The RAM needs no clearing pass: the first measurement rewrites every row.
`default_nettype none
module kalman_horizon_predictor_core
    import khp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              tick_valid,
    output logic                   tick_stall,
    input  wire tick_t             tick,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output result_t                res,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [31:0]       cfg_data
);

    typedef enum logic [21:0] {
        ST_IDLE  = 22'd1 << 0,
        ST_LOAD  = 22'd1 << 1,
        ST_LOADW = 22'd1 << 2,
        ST_SPAN  = 22'd1 << 3,
        ST_B0    = 22'd1 << 4,
        ST_B1    = 22'd1 << 5,
        ST_B2    = 22'd1 << 6,
        ST_B3    = 22'd1 << 7,
        ST_WR    = 22'd1 << 8,
        ST_DIV   = 22'd1 << 9,
        ST_DIVW  = 22'd1 << 10,
        ST_C0    = 22'd1 << 11,
        ST_C1    = 22'd1 << 12,
        ST_N0    = 22'd1 << 13,
        ST_N1    = 22'd1 << 14,
        ST_N2    = 22'd1 << 15,
        ST_SHRD  = 22'd1 << 16,
        ST_SHWR  = 22'd1 << 17,
        ST_FIN   = 22'd1 << 18,
        ST_ORD   = 22'd1 << 19,
        ST_OPOS  = 22'd1 << 20,
        ST_OVEL  = 22'd1 << 21
    } state_t;

    // Configuration registers.
    logic [15:0]        step_time_reg;
    logic [30:0]        meas_noise_reg;
    logic [30:0]        proc_pp_reg;
    logic signed [31:0] proc_pv_reg;
    logic [30:0]        proc_vv_reg;
    logic signed [31:0] init_pos_reg [AXES];

    // Control state.
    state_t      state_reg;
    mode_t       mode_reg;
    logic [1:0]  ph_reg;
    logic [K_W-1:0] k_reg;
    logic        pre_reg;
    logic        started_reg;
    logic        corrected_reg;
    logic [15:0] ext_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    // Posterior covariance per axis, and the copy staged during a tick.
    logic signed [31:0] post_p_reg [AXES];
    logic signed [31:0] post_c_reg [AXES];
    logic signed [31:0] post_v_reg [AXES];
    logic signed [31:0] pn_p_reg   [AXES];
    logic signed [31:0] pn_c_reg   [AXES];
    logic signed [31:0] pn_v_reg   [AXES];

    // Per-axis datapath.
    logic signed [31:0] a_reg, apos_reg;
    logic signed [31:0] y_reg    [AXES];
    logic signed [31:0] r0_reg   [AXES];
    logic signed [31:0] r1_reg   [AXES];
    logic signed [31:0] pp_reg   [AXES];
    logic signed [31:0] pv_reg   [AXES];
    logic signed [31:0] vv_reg   [AXES];
    logic signed [31:0] posn_reg [AXES];
    logic signed [31:0] base_reg [AXES];
    logic signed [31:0] velb_reg [AXES];
    logic signed [31:0] lp_reg   [AXES];
    logic signed [31:0] lv_reg   [AXES];
    logic signed [31:0] mul_a_reg [AXES];
    logic signed [31:0] mul_b_reg [AXES];
    logic signed [63:0] prod_reg [AXES];

    logic signed [31:0] mul_a_next [AXES];
    logic signed [31:0] mul_b_next [AXES];
    logic signed [31:0] q_val [AXES];
    logic signed [31:0] innov [AXES];
    logic signed [32:0] s_sum [AXES];
    logic               s_pos [AXES];
    logic signed [31:0] gp_q  [AXES];
    logic signed [31:0] gv_q  [AXES];
    logic [AXES-1:0]    gp_done;
    logic [AXES-1:0]    gv_done;

    logic             ram_we, ram_re;
    logic [A_W-1:0]   ram_waddr, ram_raddr;
    row_t             ram_wrow, rd_row;
    logic [ROW_W-1:0] ram_rdata;

    logic           mul_state, op_done, add_q, tick_acc, res_load, k_last, gains_done;
    logic [K_W-1:0] k_inc;
    logic [15:0]    span_k, span_pos_k;
    result_t        beat;

    function automatic logic signed [31:0] span_f(input logic [15:0] k,
                                                  input logic [15:0] ts);
        logic [31:0] p;
        p = k * ts;
        return p[31] ? S_MAX : signed'(p);
    endfunction

    function automatic logic [30:0] var_out(input logic signed [31:0] v);
        return v[31] ? 31'd0 : v[30:0];
    endfunction

    assign cfg_ready  = 1'b1;
    assign tick_stall = (state_reg != ST_IDLE);
    assign tick_acc   = tick_valid && (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign mul_state = state_reg inside {ST_B0, ST_B1, ST_B2, ST_B3, ST_C0, ST_C1,
                                         ST_N0, ST_N1, ST_N2};
    assign op_done   = (ph_reg == 2'd2);
    assign add_q     = (mode_reg != MODE_EXTRAP);
    assign k_inc     = k_reg + K_W'(1);
    assign k_last    = (k_reg == K_W'(HORIZON - 1));
    assign res_load  = (state_reg inside {ST_OPOS, ST_OVEL}) &&
                       (!res_valid_reg || !res_stall);
    assign rd_row    = row_t'(ram_rdata);
    assign gains_done = (&gp_done) && (&gv_done);

    // Spans: the prior uses k+1 steps, except at the end of an extrapolation;
    // a corrected rebuild places step k at k intervals from the new estimate.
    always_comb
    begin
        if (mode_reg == MODE_EXTRAP)
            span_k = ext_reg;
        else if (pre_reg)
            span_k = 16'd1;
        else
            span_k = 16'(k_inc);
        if (mode_reg == MODE_EXTRAP || pre_reg)
            span_pos_k = 16'd1;
        else if (mode_reg == MODE_MEAS)
            span_pos_k = 16'(k_reg);
        else
            span_pos_k = 16'(k_inc);
    end

    always_comb
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            q_val[ax] = q_of(prod_reg[ax]);
            innov[ax] = sat_sub(y_reg[ax], posn_reg[ax]);
            s_sum[ax] = {pp_reg[ax][31], pp_reg[ax]} + {2'b00, meas_noise_reg};
            s_pos[ax] = !s_sum[ax][32] && (s_sum[ax] != 33'sd0);
            case (state_reg)
                ST_B0:
                begin
                    mul_a_next[ax] = a_reg;
                    mul_b_next[ax] = post_c_reg[ax];
                end
                ST_B1:
                begin
                    mul_a_next[ax] = a_reg;
                    mul_b_next[ax] = post_v_reg[ax];
                end
                ST_B2:
                begin
                    mul_a_next[ax] = a_reg;
                    mul_b_next[ax] = r1_reg[ax];
                end
                ST_B3:
                begin
                    mul_a_next[ax] = apos_reg;
                    mul_b_next[ax] = velb_reg[ax];
                end
                ST_C0:
                begin
                    mul_a_next[ax] = lp_reg[ax];
                    mul_b_next[ax] = innov[ax];
                end
                ST_C1:
                begin
                    mul_a_next[ax] = lv_reg[ax];
                    mul_b_next[ax] = innov[ax];
                end
                ST_N0:
                begin
                    mul_a_next[ax] = lp_reg[ax];
                    mul_b_next[ax] = pp_reg[ax];
                end
                ST_N1:
                begin
                    mul_a_next[ax] = lp_reg[ax];
                    mul_b_next[ax] = pv_reg[ax];
                end
                ST_N2:
                begin
                    mul_a_next[ax] = lv_reg[ax];
                    mul_b_next[ax] = pv_reg[ax];
                end
                default:
                begin
                    mul_a_next[ax] = '0;
                    mul_b_next[ax] = '0;
                end
            endcase
        end
    end

    generate
        for (genvar gx = 0; gx < AXES; gx++)
        begin : g_gain
            khp_div u_div_p (
                .clk   (clk),
                .rst_n (rst_n),
                .start (state_reg == ST_DIV),
                .num   (pp_reg[gx]),
                .den   (s_sum[gx][31:0]),
                .done  (gp_done[gx]),
                .quo   (gp_q[gx])
            );
            khp_div u_div_v (
                .clk   (clk),
                .rst_n (rst_n),
                .start (state_reg == ST_DIV),
                .num   (pv_reg[gx]),
                .den   (s_sum[gx][31:0]),
                .done  (gv_done[gx]),
                .quo   (gv_q[gx])
            );
        end
    endgenerate

    // RAM ports.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = k_reg[A_W-1:0];
        ram_wrow  = rd_row;
        case (state_reg)
            ST_LOAD:
            begin
                ram_re    = 1'b1;
                ram_raddr = (mode_reg == MODE_EXTRAP) ? A_W'(HORIZON - 1) : '0;
            end
            ST_SHRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = k_inc[A_W-1:0];
            end
            ST_ORD:
            begin
                ram_re    = 1'b1;
                ram_raddr = k_reg[A_W-1:0];
            end
            ST_SHWR:
            begin
                ram_we = 1'b1;
            end
            ST_WR:
            begin
                ram_we = 1'b1;
                for (int ax = 0; ax < AXES; ax++)
                begin
                    ram_wrow[ax].pos  = posn_reg[ax];
                    ram_wrow[ax].vel  = velb_reg[ax];
                    ram_wrow[ax].ppos = pp_reg[ax];
                    ram_wrow[ax].pcov = pv_reg[ax];
                    ram_wrow[ax].pvel = vv_reg[ax];
                end
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    khp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (HORIZON)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ROW_W'(ram_wrow)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result beat from the row read for step k.
    always_comb
    begin
        beat.order = (state_reg == ST_OVEL);
        beat.last  = (state_reg == ST_OVEL) && k_last;
        if (state_reg == ST_OVEL)
        begin
            beat.val_x = rd_row[0].vel;
            beat.val_y = rd_row[1].vel;
            beat.val_z = rd_row[2].vel;
            beat.var_x = var_out(rd_row[0].pvel);
            beat.var_y = var_out(rd_row[1].pvel);
            beat.var_z = var_out(rd_row[2].pvel);
        end
        else
        begin
            beat.val_x = rd_row[0].pos;
            beat.val_y = rd_row[1].pos;
            beat.val_z = rd_row[2].pos;
            beat.var_x = var_out(rd_row[0].ppos);
            beat.var_y = var_out(rd_row[1].ppos);
            beat.var_z = var_out(rd_row[2].ppos);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg   <= 16'd6554;
            meas_noise_reg  <= 31'd983;
            proc_pp_reg     <= 31'd6619;
            proc_pv_reg     <= 32'sd655;
            proc_vv_reg     <= 31'd6554;
            init_pos_reg[0] <= 32'sd19661;
            init_pos_reg[1] <= 32'sd39322;
            init_pos_reg[2] <= 32'sd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STEP_TIME:  step_time_reg   <= cfg_data[15:0];
                CFG_MEAS_NOISE: meas_noise_reg  <= cfg_data[30:0];
                CFG_PROC_PP:    proc_pp_reg     <= cfg_data[30:0];
                CFG_PROC_PV:    proc_pv_reg     <= signed'(cfg_data);
                CFG_PROC_VV:    proc_vv_reg     <= cfg_data[30:0];
                CFG_INIT_X:     init_pos_reg[0] <= signed'(cfg_data);
                CFG_INIT_Y:     init_pos_reg[1] <= signed'(cfg_data);
                CFG_INIT_Z:     init_pos_reg[2] <= signed'(cfg_data);
                default:        step_time_reg   <= step_time_reg;
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MEAS;
            ph_reg        <= '0;
            k_reg         <= '0;
            pre_reg       <= 1'b0;
            started_reg   <= 1'b0;
            corrected_reg <= 1'b0;
            ext_reg       <= 16'(HORIZON);
            res_valid_reg <= 1'b0;
            for (int ax = 0; ax < AXES; ax++)
            begin
                post_p_reg[ax] <= Q_ONE;
                post_c_reg[ax] <= '0;
                post_v_reg[ax] <= Q_ONE;
            end
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (mul_state)
                ph_reg <= op_done ? 2'd0 : ph_reg + 2'd1;

            case (state_reg)
                ST_IDLE:
                begin
                    if (tick_acc && (started_reg || tick.meas_valid))
                    begin
                        if (tick.meas_valid)
                            mode_reg <= MODE_MEAS;
                        else if (corrected_reg)
                            mode_reg <= MODE_REPRED;
                        else
                            mode_reg <= MODE_EXTRAP;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_LOADW;
                end
                ST_LOADW:
                begin
                    // Every mode starts at step 0; an extrapolation with a
                    // one-step horizon has nothing to shift.
                    k_reg   <= '0;
                    pre_reg <= (mode_reg == MODE_MEAS);
                    if (mode_reg == MODE_EXTRAP && HORIZON > 1)
                        state_reg <= ST_SHRD;
                    else
                        state_reg <= ST_SPAN;
                end
                ST_SHRD:
                begin
                    state_reg <= ST_SHWR;
                end
                ST_SHWR:
                begin
                    k_reg <= k_inc;
                    if (int'(k_inc) == HORIZON - 1)
                        state_reg <= ST_SPAN;
                    else
                        state_reg <= ST_SHRD;
                end
                ST_SPAN:
                begin
                    state_reg <= ST_B0;
                end
                ST_B0:
                begin
                    if (op_done)
                        state_reg <= ST_B1;
                end
                ST_B1:
                begin
                    if (op_done)
                        state_reg <= ST_B2;
                end
                ST_B2:
                begin
                    if (op_done)
                        state_reg <= ST_B3;
                end
                ST_B3:
                begin
                    if (op_done)
                        state_reg <= pre_reg ? ST_DIV : ST_WR;
                end
                ST_WR:
                begin
                    if (k_last)
                        state_reg <= ST_FIN;
                    else
                    begin
                        k_reg     <= k_inc;
                        state_reg <= ST_SPAN;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (gains_done)
                        state_reg <= ST_C0;
                end
                ST_C0:
                begin
                    if (op_done)
                        state_reg <= ST_C1;
                end
                ST_C1:
                begin
                    if (op_done)
                        state_reg <= ST_N0;
                end
                ST_N0:
                begin
                    if (op_done)
                        state_reg <= ST_N1;
                end
                ST_N1:
                begin
                    if (op_done)
                        state_reg <= ST_N2;
                end
                ST_N2:
                begin
                    if (op_done)
                    begin
                        pre_reg   <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_SPAN;
                    end
                end
                ST_FIN:
                begin
                    for (int ax = 0; ax < AXES; ax++)
                    begin
                        post_p_reg[ax] <= pn_p_reg[ax];
                        post_c_reg[ax] <= pn_c_reg[ax];
                        post_v_reg[ax] <= pn_v_reg[ax];
                    end
                    started_reg <= 1'b1;
                    case (mode_reg)
                        MODE_MEAS:
                        begin
                            ext_reg       <= 16'(HORIZON);
                            corrected_reg <= 1'b1;
                        end
                        MODE_REPRED:
                        begin
                            corrected_reg <= 1'b0;
                        end
                        default:
                        begin
                            if (ext_reg != 16'(STEPS_MAX))
                                ext_reg <= ext_reg + 16'd1;
                        end
                    endcase
                    k_reg     <= '0;
                    state_reg <= ST_ORD;
                end
                ST_ORD:
                begin
                    state_reg <= ST_OPOS;
                end
                ST_OPOS:
                begin
                    if (res_load)
                        state_reg <= ST_OVEL;
                end
                ST_OVEL:
                begin
                    if (res_load)
                    begin
                        if (k_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            k_reg     <= k_inc;
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= beat;

        if (tick_acc)
        begin
            y_reg[0] <= tick.meas_x;
            y_reg[1] <= tick.meas_y;
            y_reg[2] <= tick.meas_z;
        end

        if (state_reg == ST_SPAN)
        begin
            a_reg    <= span_f(span_k, step_time_reg);
            apos_reg <= span_f(span_pos_k, step_time_reg);
        end

        for (int ax = 0; ax < AXES; ax++)
        begin
            mul_a_reg[ax] <= mul_a_next[ax];
            mul_b_reg[ax] <= mul_b_next[ax];
            prod_reg[ax]  <= mul_a_reg[ax] * mul_b_reg[ax];

            case (state_reg)
                ST_LOADW:
                begin
                    // Before the first measurement, step 0 starts from the
                    // initial position registers at rest.
                    if (mode_reg == MODE_MEAS && !started_reg)
                    begin
                        base_reg[ax] <= init_pos_reg[ax];
                        velb_reg[ax] <= '0;
                    end
                    else
                    begin
                        base_reg[ax] <= rd_row[ax].pos;
                        velb_reg[ax] <= rd_row[ax].vel;
                    end
                end
                ST_SHWR:
                begin
                    if (k_reg == '0)
                    begin
                        pn_p_reg[ax] <= rd_row[ax].ppos;
                        pn_c_reg[ax] <= rd_row[ax].pcov;
                        pn_v_reg[ax] <= rd_row[ax].pvel;
                    end
                end
                ST_B0:
                begin
                    if (op_done)
                        r0_reg[ax] <= sat_add(post_p_reg[ax], q_val[ax]);
                end
                ST_B1:
                begin
                    if (op_done)
                        r1_reg[ax] <= sat_add(post_c_reg[ax], q_val[ax]);
                end
                ST_B2:
                begin
                    if (op_done)
                    begin
                        if (add_q)
                        begin
                            pp_reg[ax] <= sat_add(sat_add(r0_reg[ax], q_val[ax]),
                                                  signed'({1'b0, proc_pp_reg}));
                            pv_reg[ax] <= sat_add(r1_reg[ax], proc_pv_reg);
                            vv_reg[ax] <= sat_add(post_v_reg[ax],
                                                  signed'({1'b0, proc_vv_reg}));
                        end
                        else
                        begin
                            pp_reg[ax] <= sat_add(r0_reg[ax], q_val[ax]);
                            pv_reg[ax] <= r1_reg[ax];
                            vv_reg[ax] <= post_v_reg[ax];
                        end
                    end
                end
                ST_B3:
                begin
                    if (op_done)
                        posn_reg[ax] <= sat_add(base_reg[ax], q_val[ax]);
                end
                ST_WR:
                begin
                    if (mode_reg != MODE_MEAS && k_reg == '0)
                    begin
                        pn_p_reg[ax] <= pp_reg[ax];
                        pn_c_reg[ax] <= pv_reg[ax];
                        pn_v_reg[ax] <= vv_reg[ax];
                    end
                end
                ST_DIVW:
                begin
                    // A nonpositive innovation variance leaves the step uncorrected.
                    if (gains_done)
                    begin
                        lp_reg[ax] <= s_pos[ax] ? gp_q[ax] : '0;
                        lv_reg[ax] <= s_pos[ax] ? gv_q[ax] : '0;
                    end
                end
                ST_C0:
                begin
                    if (op_done)
                        base_reg[ax] <= sat_add(posn_reg[ax], q_val[ax]);
                end
                ST_C1:
                begin
                    if (op_done)
                        velb_reg[ax] <= sat_add(velb_reg[ax], q_val[ax]);
                end
                ST_N0:
                begin
                    if (op_done)
                        pn_p_reg[ax] <= sat_sub(pp_reg[ax], q_val[ax]);
                end
                ST_N1:
                begin
                    if (op_done)
                        pn_c_reg[ax] <= sat_sub(pv_reg[ax], q_val[ax]);
                end
                ST_N2:
                begin
                    if (op_done)
                        pn_v_reg[ax] <= sat_sub(vv_reg[ax], q_val[ax]);
                end
                default:
                begin
                    r0_reg[ax] <= r0_reg[ax];
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/khp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module khp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/khp_div.sv =====
// Radix-2 divider for one Kalman gain: saturated (num * 2^16) / den, truncated.
`default_nettype none
module khp_div
    import khp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic [31:0]        den,
    output logic                    done,
    output logic signed [31:0]      quo
);

    logic [DCNT_W-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [31:0]         den_reg;
    logic [31:0]         rem_reg;
    logic [DIV_BITS-1:0] dvd_reg;

    logic [32:0] rem_sh;
    logic        fits;
    logic [31:0] mag_in;

    assign rem_sh = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};
    assign mag_in = num[31] ? (32'd0 - 32'(num)) : 32'(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[31];
            den_reg <= den;
            rem_reg <= '0;
            dvd_reg <= DIV_BITS'({mag_in, 16'd0});
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            dvd_reg <= {dvd_reg[DIV_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (dvd_reg > DIV_BITS'(64'h8000_0000))
                quo = S_MIN;
            else
                quo = 32'(DIV_BITS'(0) - dvd_reg);
        end
        else
        begin
            if (dvd_reg > DIV_BITS'(64'h7FFF_FFFF))
                quo = S_MAX;
            else
                quo = dvd_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire
